// File: hdl/swa_pkg.sv
// swa_pkg: shared types and constants for the sliding window average block
// payload structs, controller command and status structs
// no dependencies
package swa_pkg;

	localparam int SAMPLE_W = 16;
	localparam int WIN_W    = 7;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} swa_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       is_raw;
		logic                       end_of_run;
	} swa_out_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic rp_init;
		logic div_start;
		logic emit_pass;
		logic emit_avg;
		logic rp_rd;
		logic rp_emit;
		logic clear;
	} swa_cmd_t;

	typedef struct packed {
		logic w_zero;
		logic full_after;
		logic last;
		logic div_done;
		logic rp_done;
		logic out_free;
	} swa_status_t;

endpackage

// File: hdl/sliding_window_average.sv
// sliding_window_average: boxcar moving average over a stream of signed samples
// top level joining the controller and the datapath
// depends on swa_pkg, swa_ctrl, swa_dp
//
// Usage:
//   in channel (in_valid/in_ready/in_item) carries a sample and a last flag;
//   out channel (out_valid/out_ready/out_item) carries value, is_raw, end_of_run.
//   cfg_we/cfg_wdata write the window length; the running sequence is dropped.
// Operation:
//   one item is worked on at a time. A window of zero passes an item straight
//   through. While the window fills an item gives no result. With the window
//   full each item starts the bit-serial divider that forms sum / window.
//   A short sequence closed by last replays its samples, oldest first,
//   one delay line read per result.
// Reset:
//   window length is 1, sum, count and write pointer are zero, no result is held.
// Stalls:
//   a finished result sits in the output register; the next item is accepted
//   meanwhile and its work stops only where it needs the output register.
module sliding_window_average #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [swa_pkg::WIN_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  swa_pkg::swa_in_t          in_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output swa_pkg::swa_out_t         out_item
);
	import swa_pkg::*;

	swa_cmd_t    cmd;
	swa_status_t status;

	swa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	swa_dp #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// File: hdl/swa_ram.sv
// swa_ram: generic single write port, single read port memory
// registered read data, no reset on storage
// no dependencies
module swa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: hdl/swa_div.sv
// swa_div: iterative signed by unsigned divider, one quotient bit per cycle
// truncates toward zero; result narrowed to the sample width
// depends on swa_pkg
module swa_div #(
	parameter int SUM_W = 22,
	parameter int CNT_W = 7
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [SUM_W-1:0]         dividend,
	input  logic [CNT_W-1:0]                divisor,
	output logic                            done,
	output logic signed [swa_pkg::SAMPLE_W-1:0] quotient
);
	import swa_pkg::*;

	localparam int ITER_W = $clog2(SUM_W + 1);

	logic [CNT_W:0]    rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [ITER_W-1:0] cnt_q;
	logic              neg_q;
	logic              busy_q;
	logic              done_q;

	logic [CNT_W:0]    rem_shift;
	logic              qbit;
	logic [CNT_W:0]    rem_next;
	logic [SUM_W-1:0]  quo_signed;

	always_comb begin
		rem_shift = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
		qbit      = rem_shift >= {1'b0, dvs_q};
		rem_next  = qbit ? (rem_shift - {1'b0, dvs_q}) : rem_shift;
		quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
	end

	assign done     = done_q;
	assign quotient = quo_signed[SAMPLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ITER_W'(SUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == ITER_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			neg_q <= dividend[SUM_W-1];
			dvs_q <= divisor;
			quo_q <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[SUM_W-2:0], qbit};
		end
	end

endmodule

// File: hdl/swa_ctrl.sv
// swa_ctrl: sequencing state machine for the sliding window average
// drives datapath commands from channel handshakes and datapath status
// depends on swa_pkg
module swa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  swa_pkg::swa_status_t status,
	output swa_pkg::swa_cmd_t    cmd
);
	import swa_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_PASS = 7'b0000010,
		ST_UPD  = 7'b0000100,
		ST_DIVS = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_RPA  = 7'b0100000,
		ST_RPE  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = status.w_zero ? ST_PASS : ST_UPD;
				end
			end
			ST_PASS: begin
				if (status.out_free) begin
					cmd.emit_pass = 1'b1;
					cmd.clear     = status.last;
					state_d       = ST_IDLE;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				if (status.full_after) begin
					state_d = ST_DIVS;
				end else if (status.last) begin
					cmd.rp_init = 1'b1;
					state_d     = ST_RPA;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done && status.out_free) begin
					cmd.emit_avg = 1'b1;
					cmd.clear    = status.last;
					state_d      = ST_IDLE;
				end
			end
			ST_RPA: begin
				cmd.rp_rd = 1'b1;
				state_d   = ST_RPE;
			end
			ST_RPE: begin
				if (status.out_free) begin
					cmd.rp_emit = 1'b1;
					if (status.rp_done) begin
						cmd.clear = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						state_d = ST_RPA;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hdl/swa_dp.sv
// swa_dp: datapath of the sliding window average
// window register, running sum, delay line memory, divider, output register
// depends on swa_pkg, swa_ram, swa_div
module swa_dp #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [swa_pkg::WIN_W-1:0]     cfg_wdata,
	input  swa_pkg::swa_in_t              in_item,
	input  swa_pkg::swa_cmd_t             cmd,
	output swa_pkg::swa_status_t          status,
	output logic                          out_valid,
	input  logic                          out_ready,
	output swa_pkg::swa_out_t             out_item
);
	import swa_pkg::*;

	localparam int PTR_W = $clog2(MAX_WINDOW);
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = SAMPLE_W + PTR_W;

	function automatic logic [PTR_W-1:0] sub_wrap(input logic [PTR_W-1:0] a,
	                                              input logic [CNT_W-1:0] b);
		logic [CNT_W:0] ae;
		logic [CNT_W:0] be;
		logic [CNT_W:0] r;
		ae = (CNT_W+1)'(a);
		be = (CNT_W+1)'(b);
		if (ae >= be) begin
			r = ae - be;
		end else begin
			r = ae + (CNT_W+1)'(MAX_WINDOW) - be;
		end
		return r[PTR_W-1:0];
	endfunction

	function automatic logic [PTR_W-1:0] add_wrap(input logic [PTR_W-1:0] a,
	                                              input logic [CNT_W-1:0] b);
		logic [CNT_W:0] r;
		r = (CNT_W+1)'(a) + (CNT_W+1)'(b);
		if (r >= (CNT_W+1)'(MAX_WINDOW)) begin
			r = r - (CNT_W+1)'(MAX_WINDOW);
		end
		return r[PTR_W-1:0];
	endfunction

	logic [WIN_W-1:0]           win_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]           seen_q;
	logic [PTR_W-1:0]           ptr_q;
	logic [CNT_W-1:0]           rp_idx_q;
	logic [SAMPLE_W-1:0]        sample_q;
	logic                       last_q;
	logic                       out_valid_q;
	swa_out_t                   out_q;

	logic [CNT_W-1:0]           w;
	logic                       full;
	logic [PTR_W-1:0]           old_idx;
	logic [PTR_W-1:0]           rp_addr;
	logic                       rp_done;
	logic [SAMPLE_W-1:0]        rd_data;
	logic signed [SUM_W-1:0]    sample_ext;
	logic signed [SUM_W-1:0]    old_ext;
	logic                       div_done;
	logic signed [SAMPLE_W-1:0] div_quo;
	logic                       out_free;

	always_comb begin
		w = (win_q > WIN_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : win_q[CNT_W-1:0];
		full       = seen_q >= w;
		old_idx    = sub_wrap(ptr_q, w);
		rp_addr    = add_wrap(sub_wrap(ptr_q, seen_q), rp_idx_q);
		rp_done    = ((CNT_W+1)'(rp_idx_q) + 1'b1) == (CNT_W+1)'(seen_q);
		sample_ext = {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
		old_ext    = {{(SUM_W-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};
		out_free   = !out_valid_q || out_ready;
	end

	always_comb begin
		status.w_zero     = win_q == '0;
		status.full_after = full || (((CNT_W+1)'(seen_q) + 1'b1) >= (CNT_W+1)'(w));
		status.last       = last_q;
		status.div_done   = div_done;
		status.rp_done    = rp_done;
		status.out_free   = out_free;
	end

	swa_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_WINDOW)
	) u_delay (
		.clk     (clk),
		.wr_en   (cmd.update),
		.wr_addr (ptr_q),
		.wr_data (sample_q),
		.rd_en   (cmd.capture | cmd.rp_rd),
		.rd_addr (cmd.capture ? old_idx : rp_addr),
		.rd_data (rd_data)
	);

	swa_div #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (w),
		.done     (div_done),
		.quotient (div_quo)
	);

	// window register and sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= WIN_W'(1);
			sum_q  <= '0;
			seen_q <= '0;
			ptr_q  <= '0;
		end else if (cfg_we) begin
			win_q  <= cfg_wdata;
			sum_q  <= '0;
			seen_q <= '0;
			ptr_q  <= '0;
		end else if (cmd.clear) begin
			sum_q  <= '0;
			seen_q <= '0;
			ptr_q  <= '0;
		end else if (cmd.update) begin
			if (full) begin
				sum_q <= sum_q - old_ext + sample_ext;
			end else begin
				sum_q  <= sum_q + sample_ext;
				seen_q <= seen_q + 1'b1;
			end
			ptr_q <= (ptr_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= in_item.sample;
			last_q   <= in_item.last;
		end
		if (cmd.rp_init) begin
			rp_idx_q <= '0;
		end else if (cmd.rp_emit) begin
			rp_idx_q <= rp_idx_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_pass || cmd.emit_avg || cmd.rp_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.emit_pass) begin
			out_q.value      <= sample_q;
			out_q.is_raw     <= 1'b1;
			out_q.end_of_run <= last_q;
		end else if (cmd.emit_avg) begin
			out_q.value      <= div_quo;
			out_q.is_raw     <= 1'b0;
			out_q.end_of_run <= last_q;
		end else if (cmd.rp_emit) begin
			out_q.value      <= rd_data;
			out_q.is_raw     <= 1'b1;
			out_q.end_of_run <= rp_done;
		end else begin
			out_q <= out_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// File: tb/sv/sliding_window_average_test.sv
// sliding_window_average_test: self-checking bench for the boxcar moving average block
// a scoreboard class predicts averages, pass-throughs and raw replays; plain tasks drive samples and windows
// depends on swa_pkg and sliding_window_average
module sliding_window_average_test;
	import swa_pkg::*;

	localparam int DEPTH = 64;
	localparam int SETTLE = 40;
	localparam int CYCLE_LIMIT = 200000;
	localparam int CALM_AFTER = 220;
	localparam int STOP_AFTER = 250;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'h7fff;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'h8000;

	typedef enum int {MIXED, ALL_MAX, ALL_MIN} fill_style_t;

	class boxcar_scoreboard;
		logic [WIN_W-1:0] window_len;
		logic signed [SAMPLE_W-1:0] taps [DEPTH];
		logic signed [21:0] acc;
		logic [6:0] filled;
		logic [5:0] wr_ptr;
		swa_out_t expected_q[$];
		int mismatches;

		function new();
			window_len = WIN_W'(1);
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			acc = '0;
			filled = '0;
			wr_ptr = '0;
		endfunction

		function void set_window(logic [WIN_W-1:0] w);
			window_len = w;
			restart();
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function bit clean();
			return mismatches == 0 && expected_q.size() == 0;
		endfunction

		function void note_sample(swa_in_t it);
			logic [6:0] span;
			logic [5:0] idx;
			int quotient;
			swa_out_t r;
			span = (window_len > DEPTH) ? 7'(DEPTH) : window_len;
			if (span == 0) begin
				r.value = it.sample;
				r.is_raw = 1'b1;
				r.end_of_run = it.last;
				expected_q.push_back(r);
				if (it.last)
					restart();
				return;
			end
			if (filled >= span) begin
				idx = wr_ptr - span[5:0];
				acc = acc - taps[idx] + $signed(it.sample);
			end else begin
				acc = acc + $signed(it.sample);
				filled = filled + 7'd1;
			end
			taps[wr_ptr] = it.sample;
			wr_ptr = wr_ptr + 6'd1;
			if (filled >= span) begin
				quotient = int'(acc) / int'(span);
				r.value = SAMPLE_W'(quotient);
				r.is_raw = 1'b0;
				r.end_of_run = it.last;
				expected_q.push_back(r);
			end else if (it.last) begin
				// short sequence: replay what was stored, oldest first
				idx = wr_ptr - filled[5:0];
				for (int i = 0; i < filled; i++) begin
					r.value = taps[idx];
					r.is_raw = 1'b1;
					r.end_of_run = (i == filled - 1);
					expected_q.push_back(r);
					idx = idx + 6'd1;
				end
			end
			if (it.last)
				restart();
		endfunction

		function void log_error(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%s", msg);
		endfunction

		function void check_result(swa_out_t got);
			swa_out_t want;
			if (expected_q.size() == 0) begin
				log_error($sformatf("unexpected result: value=%0d is_raw=%0b end_of_run=%0b",
					got.value, got.is_raw, got.end_of_run));
				return;
			end
			want = expected_q.pop_front();
			if (got.value !== want.value || got.is_raw !== want.is_raw ||
					got.end_of_run !== want.end_of_run)
				log_error($sformatf({"result error: expected value=%0d is_raw=%0b end_of_run=%0b,",
					" got value=%0d is_raw=%0b end_of_run=%0b"},
					want.value, want.is_raw, want.end_of_run,
					got.value, got.is_raw, got.end_of_run));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [WIN_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	swa_in_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	swa_out_t out_item;

	boxcar_scoreboard board = new();
	logic [WIN_W-1:0] window_plan [10] = '{7'd2, 7'd64, 7'd0, 7'd5, 7'd127,
		7'd1, 7'd13, 7'd3, 7'd64, 7'd8};
	bit calm = 1'b0;
	int stall_left = 0;
	int cycles = 0;
	int sent = 0;

	sliding_window_average dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(out_item);
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 16);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic fin);
		swa_in_t it;
		it.sample = s;
		it.last = fin;
		if (sent >= CALM_AFTER)
			calm = 1'b1;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		board.note_sample(it);
		sent++;
		@(negedge clk);
	endtask

	task automatic write_window(input logic [WIN_W-1:0] w);
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_wdata <= w;
		cfg_we <= 1'b1;
		@(posedge clk);
		board.set_window(w);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_sequence(input int length, input bit closed, input fill_style_t style);
		logic signed [SAMPLE_W-1:0] s;
		logic fin;
		int pick;
		for (int i = 0; i < length; i++) begin
			pick = $urandom_range(0, 7);
			case (style)
				ALL_MAX: s = S_MAX;
				ALL_MIN: s = S_MIN;
				default: begin
					if (pick == 0)
						s = S_MAX;
					else if (pick == 1)
						s = S_MIN;
					else if (pick == 2)
						s = '0;
					else
						s = SAMPLE_W'($urandom());
				end
			endcase
			fin = (i == length - 1) ? closed : ($urandom_range(0, 29) == 0);
			push_sample(s, fin);
		end
	endtask

	initial begin
		logic [WIN_W-1:0] w;
		int span;
		int length;
		int budget;
		int phase_items;
		fill_style_t style;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// window of one after reset
		push_sample(S_MAX, 1'b0);
		push_sample(S_MIN, 1'b0);
		push_sample(16'sd0, 1'b0);
		push_sample(-16'sd1, 1'b1);
		// pass-through
		write_window(7'd0);
		push_sample(S_MAX, 1'b0);
		push_sample(S_MIN, 1'b1);
		push_sample(16'sd1, 1'b0);
		// negative sums truncate toward zero, then a short sequence
		write_window(7'd3);
		push_sample(-16'sd1, 1'b0);
		push_sample(-16'sd1, 1'b0);
		push_sample(16'sd0, 1'b0);
		push_sample(16'sd5, 1'b0);
		push_sample(-16'sd7, 1'b1);
		push_sample(16'sd7, 1'b0);
		push_sample(-16'sd3, 1'b1);
		// oversized window saturates
		write_window(7'd127);
		push_sample(S_MIN, 1'b0);
		push_sample(16'sd12, 1'b0);
		push_sample(S_MAX, 1'b1);
		// sequence of a single sample
		write_window(7'd2);
		push_sample(-16'sd5, 1'b1);

		for (int p = 0; sent < STOP_AFTER; p++) begin
			w = (p < 10) ? window_plan[p] : WIN_W'($urandom_range(0, 20));
			span = (w > DEPTH) ? DEPTH : int'(w);
			write_window(w);
			phase_items = 0;
			budget = (span + 10 > 30) ? span + 10 : 30;
			while (phase_items < budget && sent < STOP_AFTER) begin
				if ($urandom_range(0, 3) == 0)
					length = $urandom_range(1, (span > 1) ? span - 1 : 1);
				else
					length = $urandom_range((span > 0) ? span : 1, span + 10);
				case ($urandom_range(0, 5))
					0: style = ALL_MAX;
					1: style = ALL_MIN;
					default: style = MIXED;
				endcase
				run_sequence(length, $urandom_range(0, 9) != 0, style);
				phase_items += length;
			end
		end

		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (board.clean())
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
